### hdl/lrmcu_pkg.sv
// Shared types and constants for the learned remote motor command unit.
// Used by lrmcu_cell, lrmcu_cmd and learned_remote_motor_command_unit_core.
package lrmcu_pkg;

   localparam int NUM_COMMANDS       = 9;
   localparam int CODE_WIDTH_DEFAULT = 32;
   localparam int TAKEN_WIDTH        = 4;
   localparam int COUNT_WIDTH        = 17;
   localparam int RSP_DATA_WIDTH     = 32;

   localparam logic [TAKEN_WIDTH-1:0] SLOT_NONE   = TAKEN_WIDTH'(NUM_COMMANDS);
   localparam logic [TAKEN_WIDTH-1:0] TAKEN_LEARN = TAKEN_WIDTH'(NUM_COMMANDS + 1);

   localparam logic [COUNT_WIDTH-1:0] LOW_STEP = COUNT_WIDTH'(8000);
   localparam logic [COUNT_WIDTH-1:0] LOW_MIN  = COUNT_WIDTH'(8000);
   localparam logic [COUNT_WIDTH-1:0] LOW_MAX  = COUNT_WIDTH'(72000);

   typedef enum logic [TAKEN_WIDTH-1:0] {
      CMD_SLOW_DOWN    = 4'd0,
      CMD_RUN          = 4'd1,
      CMD_SPEED_UP     = 4'd2,
      CMD_TOGGLE_LEFT  = 4'd3,
      CMD_TOGGLE_RIGHT = 4'd4,
      CMD_STOP         = 4'd5,
      CMD_REVERSE      = 4'd6,
      CMD_AUTO_ON      = 4'd7,
      CMD_AUTO_OFF     = 4'd8
   } cmd_type;

   typedef enum logic [1:0] {
      MOTOR_STOPPED = 2'd0,
      MOTOR_FORWARD = 2'd1,
      MOTOR_REVERSE = 2'd2
   } motor_type;

   typedef enum logic [1:0] {
      STEER_OFF   = 2'd0,
      STEER_LEFT  = 2'd1,
      STEER_RIGHT = 2'd2
   } steer_type;

   // Control part of an item as it travels down the cell row
   typedef struct packed {
      logic                   store;
      logic                   match;
      logic [TAKEN_WIDTH-1:0] slot;
      logic [TAKEN_WIDTH-1:0] taken;
   } ctrl_type;

   typedef struct packed {
      logic [TAKEN_WIDTH-1:0] taken;
      logic                   ack;
      logic                   auto_en;
      logic [COUNT_WIDTH-1:0] low_count;
      steer_type              steer;
      motor_type              motor;
   } result_type;

endpackage

### hdl/learned_remote_motor_command_unit_core.sv
// Learned remote motor command unit: learn stage, row of code cells, command stage.
// Depends on lrmcu_pkg, lrmcu_cell and lrmcu_cmd.
// Pipeline: one register per table slot in the cell row plus the command stage
// register lie between item accept and result valid.
// Throughput: one item per cycle; each cell and the command stage take an item
// whenever they are empty or their own item moves on.
// Reset: clears learned count, motor/steering/auto state, count to 72000 and
// repeat code to all ones; table slots stay undefined until learned.
module learned_remote_motor_command_unit_core #(
   parameter int CODE_WIDTH = lrmcu_pkg::CODE_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // [CODE_WIDTH-1:0] ir_code, zero padding above
   input  logic [((CODE_WIDTH + 7) / 8) * 8-1:0]  req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [1:0] motor_mode, [3:2] steer_drive, [20:4] drive_low_count,
   // [21] auto_enabled, [22] learn_ack, [26:23] command_taken, zero above
   output logic [lrmcu_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   input  logic                                   csr_we,
   input  logic [CODE_WIDTH-1:0]                  csr_wdata
);
   import lrmcu_pkg::*;

   localparam int RESULT_WIDTH = $bits(result_type);

   logic [CODE_WIDTH-1:0]  repeat_code_ff;
   logic [TAKEN_WIDTH-1:0] learned_count_ff;
   logic                   learning;
   logic [CODE_WIDTH-1:0]  code;
   ctrl_type               entry_ctrl;
   logic                   accept;

   logic                  valid_chain [0:NUM_COMMANDS];
   logic                  ready_chain [0:NUM_COMMANDS];
   logic [CODE_WIDTH-1:0] code_chain  [0:NUM_COMMANDS];
   ctrl_type              ctrl_chain  [0:NUM_COMMANDS];

   result_type result;

   assign code     = req_tdata[CODE_WIDTH-1:0];
   assign learning = (learned_count_ff < TAKEN_WIDTH'(NUM_COMMANDS));

   always_comb begin
      entry_ctrl.store = learning && (code != repeat_code_ff);
      entry_ctrl.match = !learning;
      entry_ctrl.slot  = learned_count_ff;
      entry_ctrl.taken = learning ? TAKEN_LEARN : SLOT_NONE;
   end

   assign req_tready     = ready_chain[0];
   assign accept         = req_tvalid && req_tready;
   assign valid_chain[0] = req_tvalid;
   assign code_chain[0]  = code;
   assign ctrl_chain[0]  = entry_ctrl;

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_code_ff   <= '1;
         learned_count_ff <= '0;
      end else begin
         if (csr_we) begin
            repeat_code_ff <= csr_wdata;
         end
         // advance the fill count only for codes actually stored
         if (accept && entry_ctrl.store) begin
            learned_count_ff <= learned_count_ff + TAKEN_WIDTH'(1);
         end
      end
   end

   for (genvar i = 0; i < NUM_COMMANDS; i++) begin : g_cell
      lrmcu_cell #(
         .CODE_WIDTH (CODE_WIDTH),
         .SLOT_IDX   (TAKEN_WIDTH'(i))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_chain[i]),
         .in_ready  (ready_chain[i]),
         .in_code   (code_chain[i]),
         .in_ctrl   (ctrl_chain[i]),
         .out_valid (valid_chain[i+1]),
         .out_ready (ready_chain[i+1]),
         .out_code  (code_chain[i+1]),
         .out_ctrl  (ctrl_chain[i+1])
      );
   end

   lrmcu_cmd u_cmd (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (valid_chain[NUM_COMMANDS]),
      .in_ready   (ready_chain[NUM_COMMANDS]),
      .in_ctrl    (ctrl_chain[NUM_COMMANDS]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   // the last cell's code is not consumed by anything
   assign rsp_tdata = {{(RSP_DATA_WIDTH - RESULT_WIDTH){1'b0}}, result};

endmodule

### hdl/lrmcu_cell.sv
// One cell of the code row: holds one learned table slot and one item in flight.
// Depends on lrmcu_pkg.
module lrmcu_cell #(
   parameter int                                   CODE_WIDTH = lrmcu_pkg::CODE_WIDTH_DEFAULT,
   parameter logic [lrmcu_pkg::TAKEN_WIDTH-1:0]    SLOT_IDX   = '0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [CODE_WIDTH-1:0] in_code,
   input  lrmcu_pkg::ctrl_type   in_ctrl,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [CODE_WIDTH-1:0] out_code,
   output lrmcu_pkg::ctrl_type   out_ctrl
);
   import lrmcu_pkg::*;

   logic                  valid_ff;
   logic [CODE_WIDTH-1:0] code_ff;
   ctrl_type              ctrl_ff;
   ctrl_type              ctrl_in;
   logic [CODE_WIDTH-1:0] slot_code_ff;
   logic                  take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   // first match wins: only claim the item if no earlier slot has
   always_comb begin
      ctrl_in = in_ctrl;
      if (in_ctrl.match && (in_ctrl.taken == SLOT_NONE) && (slot_code_ff == in_code)) begin
         ctrl_in.taken = SLOT_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         code_ff <= in_code;
         ctrl_ff <= ctrl_in;
      end
      if (take && in_ctrl.store && (in_ctrl.slot == SLOT_IDX)) begin
         slot_code_ff <= in_code;
      end
   end

   assign out_valid = valid_ff;
   assign out_code  = code_ff;
   assign out_ctrl  = ctrl_ff;

endmodule

### hdl/lrmcu_cmd.sv
// Command stage: runs the matched command on the motor, steering, count and auto
// state and holds the result item. Depends on lrmcu_pkg.
module lrmcu_cmd (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  lrmcu_pkg::ctrl_type   in_ctrl,
   output logic                  out_valid,
   input  logic                  out_ready,
   output lrmcu_pkg::result_type out_result
);
   import lrmcu_pkg::*;

   logic                   valid_ff;
   result_type             result_ff;
   motor_type              motor_ff,  motor_in;
   steer_type              steer_ff,  steer_in;
   steer_type              turn_ff,   turn_in;
   logic [COUNT_WIDTH-1:0] low_ff,    low_in;
   logic                   auto_ff,   auto_in;
   logic                   take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      motor_in = motor_ff;
      steer_in = steer_ff;
      turn_in  = turn_ff;
      low_in   = low_ff;
      auto_in  = auto_ff;
      unique case (cmd_type'(in_ctrl.taken))
         CMD_SLOW_DOWN: begin
            if ((motor_ff != MOTOR_STOPPED) && (low_ff > LOW_MIN)) begin
               low_in = low_ff - LOW_STEP;
            end
            turn_in = STEER_OFF;
         end
         CMD_RUN: begin
            motor_in = MOTOR_FORWARD;
            turn_in  = STEER_OFF;
         end
         CMD_SPEED_UP: begin
            if ((motor_ff != MOTOR_STOPPED) && (low_ff < LOW_MAX)) begin
               low_in = low_ff + LOW_STEP;
            end
            turn_in = STEER_OFF;
         end
         CMD_TOGGLE_LEFT: begin
            if (turn_ff == STEER_LEFT) begin
               steer_in = STEER_OFF;
               turn_in  = STEER_OFF;
            end else begin
               steer_in = STEER_LEFT;
               turn_in  = STEER_LEFT;
            end
         end
         CMD_TOGGLE_RIGHT: begin
            if (turn_ff == STEER_RIGHT) begin
               steer_in = STEER_OFF;
               turn_in  = STEER_OFF;
            end else begin
               steer_in = STEER_RIGHT;
               turn_in  = STEER_RIGHT;
            end
         end
         CMD_STOP: begin
            motor_in = MOTOR_STOPPED;
            steer_in = STEER_OFF;
            turn_in  = STEER_OFF;
         end
         CMD_REVERSE: begin
            motor_in = MOTOR_REVERSE;
            turn_in  = STEER_OFF;
         end
         CMD_AUTO_ON: begin
            auto_in  = 1'b1;
            motor_in = MOTOR_FORWARD;
         end
         CMD_AUTO_OFF: begin
            auto_in  = 1'b0;
            motor_in = MOTOR_STOPPED;
            steer_in = STEER_OFF;
            turn_in  = STEER_OFF;
         end
         default: begin
            // no match, learning or ignored: hold state
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         motor_ff <= MOTOR_STOPPED;
         steer_ff <= STEER_OFF;
         turn_ff  <= STEER_OFF;
         low_ff   <= LOW_MAX;
         auto_ff  <= 1'b0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (take) begin
            motor_ff <= motor_in;
            steer_ff <= steer_in;
            turn_ff  <= turn_in;
            low_ff   <= low_in;
            auto_ff  <= auto_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff.taken     <= in_ctrl.taken;
         result_ff.ack       <= in_ctrl.store;
         result_ff.auto_en   <= auto_in;
         result_ff.low_count <= low_in;
         result_ff.steer     <= steer_in;
         result_ff.motor     <= motor_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

### tb/sv/lrmcu_tb_pkg.sv
// Result tracker for the learned remote motor command unit testbench.
// Mirrors the learn table and motor state, and checks result items in order.
// Depends on lrmcu_pkg for the command, motor, steering and result types.
package lrmcu_tb_pkg;

   import lrmcu_pkg::*;

   class motor_cmd_tracker;
      logic [31:0]            repeat_code;
      logic [31:0]            code_table [NUM_COMMANDS];
      int unsigned            learned;
      logic [COUNT_WIDTH-1:0] low_count;
      motor_type              motor;
      steer_type              steer;
      steer_type              turn_mem;
      logic                   auto_en;
      result_type             pending_results [$];
      int unsigned            results_seen;
      int unsigned            mismatches;

      function new();
         repeat_code  = '1;
         learned      = 0;
         low_count    = LOW_MAX;
         motor        = MOTOR_STOPPED;
         steer        = STEER_OFF;
         turn_mem     = STEER_OFF;
         auto_en      = 1'b0;
         results_seen = 0;
         mismatches   = 0;
      endfunction

      function void set_repeat_code(logic [31:0] value);
         repeat_code = value;
      endfunction

      function void run_command(cmd_type cmd);
         case (cmd)
            CMD_SLOW_DOWN: begin
               if (motor != MOTOR_STOPPED && low_count > LOW_MIN)
                  low_count = low_count - LOW_STEP;
               turn_mem = STEER_OFF;
            end
            CMD_RUN: begin
               motor    = MOTOR_FORWARD;
               turn_mem = STEER_OFF;
            end
            CMD_SPEED_UP: begin
               if (motor != MOTOR_STOPPED && low_count < LOW_MAX)
                  low_count = low_count + LOW_STEP;
               turn_mem = STEER_OFF;
            end
            CMD_TOGGLE_LEFT: begin
               if (turn_mem == STEER_LEFT) begin
                  steer    = STEER_OFF;
                  turn_mem = STEER_OFF;
               end else begin
                  steer    = STEER_LEFT;
                  turn_mem = STEER_LEFT;
               end
            end
            CMD_TOGGLE_RIGHT: begin
               if (turn_mem == STEER_RIGHT) begin
                  steer    = STEER_OFF;
                  turn_mem = STEER_OFF;
               end else begin
                  steer    = STEER_RIGHT;
                  turn_mem = STEER_RIGHT;
               end
            end
            CMD_STOP: begin
               motor    = MOTOR_STOPPED;
               steer    = STEER_OFF;
               turn_mem = STEER_OFF;
            end
            CMD_REVERSE: begin
               motor    = MOTOR_REVERSE;
               turn_mem = STEER_OFF;
            end
            CMD_AUTO_ON: begin
               auto_en = 1'b1;
               motor   = MOTOR_FORWARD;
            end
            default: begin
               auto_en  = 1'b0;
               motor    = MOTOR_STOPPED;
               steer    = STEER_OFF;
               turn_mem = STEER_OFF;
            end
         endcase
      endfunction

      // Predict the result of one accepted code and queue it
      function void accept_code(logic [31:0] code);
         result_type r;
         logic       hit;
         r.ack   = 1'b0;
         r.taken = TAKEN_LEARN;
         if (learned < NUM_COMMANDS) begin
            if (code != repeat_code) begin
               code_table[learned] = code;
               learned++;
               r.ack = 1'b1;
            end
         end else begin
            r.taken = SLOT_NONE;
            hit     = 1'b0;
            // first matching slot wins
            for (int i = 0; i < NUM_COMMANDS; i++) begin
               if (!hit && code_table[i] == code) begin
                  r.taken = TAKEN_WIDTH'(i);
                  hit     = 1'b1;
               end
            end
            if (hit)
               run_command(cmd_type'(r.taken));
         end
         r.motor     = motor;
         r.steer     = steer;
         r.low_count = low_count;
         r.auto_en   = auto_en;
         pending_results.push_back(r);
      endfunction

      function void check_result(logic [RSP_DATA_WIDTH-1:0] data);
         result_type want;
         result_type got;
         logic       bad;
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("result item with nothing pending: %h", data);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         got  = result_type'(data[26:0]);
         bad  = 1'b0;
         if (got.motor !== want.motor) begin
            $error("motor_mode: expected %0d, got %0d", want.motor, got.motor);
            bad = 1'b1;
         end
         if (got.steer !== want.steer) begin
            $error("steer_drive: expected %0d, got %0d", want.steer, got.steer);
            bad = 1'b1;
         end
         if (got.low_count !== want.low_count) begin
            $error("drive_low_count: expected %0d, got %0d", want.low_count, got.low_count);
            bad = 1'b1;
         end
         if (got.auto_en !== want.auto_en) begin
            $error("auto_enabled: expected %0d, got %0d", want.auto_en, got.auto_en);
            bad = 1'b1;
         end
         if (got.ack !== want.ack) begin
            $error("learn_ack: expected %0d, got %0d", want.ack, got.ack);
            bad = 1'b1;
         end
         if (got.taken !== want.taken) begin
            $error("command_taken: expected %0d, got %0d", want.taken, got.taken);
            bad = 1'b1;
         end
         if (data[RSP_DATA_WIDTH-1:27] !== '0) begin
            $error("padding: expected 0, got %h", data[RSP_DATA_WIDTH-1:27]);
            bad = 1'b1;
         end
         if (bad)
            mismatches++;
      endfunction
   endclass

endpackage

### tb/sv/tb_top.sv
// Top-level testbench for learned_remote_motor_command_unit_core.
// Learns a command table, then drives command sequences and noise with random idling.
// Depends on lrmcu_pkg and lrmcu_tb_pkg.
module tb_top;

   import lrmcu_pkg::*;
   import lrmcu_tb_pkg::*;

   localparam int          CYCLE_LIMIT = 200000;
   localparam int          PHASE_ITEMS = 400;
   localparam logic [31:0] MID_REPEAT  = 32'h5A5A_A5A5;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [31:0]               req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      csr_we     = 1'b0;
   logic [31:0]               csr_wdata  = '0;

   motor_cmd_tracker tracker;
   logic [31:0]      learned_codes [NUM_COMMANDS];
   int               gap_odds    = 0;
   int               stall_odds  = 0;
   int               stall_left  = 0;
   int               cycle_count = 0;
   int               codes_sent  = 0;

   learned_remote_motor_command_unit_core #(
      .CODE_WIDTH(32)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // Receiver: stall in bursts, started at random with odds set by stall_odds
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
         stall_left = $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_result(rsp_tdata);
   end

   function automatic logic code_known(logic [31:0] code);
      for (int i = 0; i < NUM_COMMANDS; i++)
         if (learned_codes[i] == code)
            return 1'b1;
      return 1'b0;
   endfunction

   // Hold the item until accepted; valid stays high for a following item
   task automatic send_code(logic [31:0] code);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= code;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.accept_code(code);
      codes_sent++;
   endtask

   task automatic send_command(cmd_type cmd);
      send_code(learned_codes[cmd]);
   endtask

   // Drain the block before touching the repeat code register
   task automatic write_repeat_code(logic [31:0] value);
      req_tvalid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      tracker.set_repeat_code(value);
   endtask

   task automatic run_phase(logic [31:0] repeat_value, logic quiet);
      int      count;
      int      pick;
      int      reps;
      cmd_type cmd;
      logic [31:0] code;
      write_repeat_code(repeat_value);
      count = 0;
      while (count < PHASE_ITEMS) begin
         if (quiet) begin
            gap_odds   = 0;
            stall_odds = 0;
         end else begin
            pick       = $urandom_range(0, 2);
            gap_odds   = (pick == 0) ? 0 : (pick == 1) ? 2 : 6;
            pick       = $urandom_range(0, 2);
            stall_odds = (pick == 0) ? 0 : (pick == 1) ? 2 : 6;
         end
         if ($urandom_range(0, 99) < 85) begin
            // weight the count commands so both limits get reached
            pick = $urandom_range(0, 11);
            if (pick == 9 || pick == 10)
               cmd = CMD_SLOW_DOWN;
            else if (pick == 11)
               cmd = CMD_SPEED_UP;
            else
               cmd = cmd_type'(pick);
            reps = (cmd == CMD_SLOW_DOWN || cmd == CMD_SPEED_UP) ?
                   $urandom_range(1, 10) : $urandom_range(1, 2);
            repeat (reps) send_command(cmd);
            count += reps;
         end else begin
            if ($urandom_range(0, 1) == 0) begin
               code = $urandom;
            end else begin
               code = learned_codes[$urandom_range(0, NUM_COMMANDS - 1)];
               code[$urandom_range(0, 31)] ^= 1'b1;
            end
            send_code(code);
            count++;
         end
      end
   endtask

   initial begin
      logic [31:0] code;
      tracker = new();
      learned_codes[0] = '0;
      learned_codes[1] = '1;
      for (int i = 2; i < NUM_COMMANDS; i++)
         learned_codes[i] = '0;
      for (int i = 2; i < NUM_COMMANDS; i++) begin
         do code = $urandom; while (code_known(code) || code == MID_REPEAT);
         learned_codes[i] = code;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      gap_odds   = 3;
      stall_odds = 3;

      // Repeat codes are dropped while learning, under several register values
      send_code('1);
      write_repeat_code('0);
      send_code('0);
      write_repeat_code(MID_REPEAT);
      send_code(MID_REPEAT);
      for (int i = 0; i < NUM_COMMANDS; i++)
         send_code(learned_codes[i]);

      write_repeat_code('1);
      send_command(CMD_SLOW_DOWN);
      send_command(CMD_RUN);
      send_command(CMD_SPEED_UP);
      send_command(CMD_SLOW_DOWN);
      send_command(CMD_TOGGLE_LEFT);
      send_command(CMD_TOGGLE_LEFT);
      send_command(CMD_TOGGLE_RIGHT);
      send_command(CMD_TOGGLE_LEFT);
      send_command(CMD_REVERSE);
      send_command(CMD_AUTO_ON);
      send_command(CMD_AUTO_OFF);
      send_command(CMD_STOP);
      do code = $urandom; while (code_known(code));
      send_code(code);
      // the repeat code now matches its slot like any other code
      send_code('1);

      run_phase($urandom, 1'b0);
      run_phase('0, 1'b0);
      run_phase(learned_codes[CMD_RUN], 1'b0);
      run_phase('1, 1'b1);

      req_tvalid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d codes: learning with dropped repeat codes, all nine commands,",
               codes_sent);
      $display("unmatched codes and both count limits; %0d results checked, %0d bad.",
               tracker.results_seen, tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
